@@ design/lesf_pkg.sv @@
// Package with shared types and register indexes for the largest empty square finder.
package lesf_pkg;

  localparam int CHAR_W = 8;
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;
  localparam int CFG_IDX_W = 1;

  typedef logic [CHAR_W-1:0]    char_t;
  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_EMPTY_CHAR = 1'b0;
  localparam cfg_idx_t CFG_ROW_WIDTH  = 1'b1;

  localparam char_t EMPTY_CHAR_RST = 8'd46;
  localparam size_t ROW_WIDTH_RST  = 11'd1024;

endpackage

@@ design/lesf_if.sv @@
// Request channel interfaces for grid cells in and square results out.
interface lesf_in_if;
  logic               valid;
  logic               ready;
  lesf_pkg::char_t    cell_char;
  logic               last_cell;

  modport source (output valid, output cell_char, output last_cell, input ready);
  modport sink   (input valid, input cell_char, input last_cell, output ready);
endinterface

interface lesf_out_if;
  logic               valid;
  logic               ready;
  lesf_pkg::size_t    cell_size;
  lesf_pkg::size_t    best_size;
  lesf_pkg::pos_t     best_row;
  lesf_pkg::pos_t     best_col;
  logic               grid_done;

  modport source (output valid, output cell_size, output best_size, output best_row,
                  output best_col, output grid_done, input ready);
  modport sink   (input valid, input cell_size, input best_size, input best_row,
                  input best_col, input grid_done, output ready);
endinterface

@@ design/lesf_line_store.sv @@
// Line store holding the previous row's square sizes, with write-to-read bypass.
module lesf_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  lesf_pkg::size_t     wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output lesf_pkg::size_t     rd_data
);
  import lesf_pkg::*;

  size_t mem [DEPTH];
  size_t rd_q_r;
  logic  byp_r;
  size_t byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // A write landing on the address being read in the same cycle wins.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

@@ design/largest_empty_square_finder_top.sv @@
// Top level of the largest empty square finder.
//
// Grid characters stream in raster order, one request per cell, and every cell
// produces one result request: the side of the largest free square whose
// bottom-right corner is that cell, plus the best side found so far in the grid
// and the row and column where it ends. The block sustains one cell per clock
// cycle while results drain; that figure is set by the line store, which takes
// one read and one write per cycle. Each cell is registered with its line-store
// read, then the square size is formed and held in the output register. A new
// cell is accepted while a finished result waits at the output if the cell stage
// is empty. The result that carries the last-cell flag has grid_done set and
// the final best; the position counters and the best then return to zero for
// the next grid. The line store needs no clearing pass: its first-row reads go
// unused. Configuration (empty character, row width) must be written only
// while idle; the block does not enforce this.
module largest_empty_square_finder_top #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lesf_in_if.sink               in_s,
  lesf_out_if.source            out_m,
  input  logic                  cfg_we,
  input  lesf_pkg::cfg_idx_t    cfg_idx,
  input  lesf_pkg::size_t       cfg_wdata
);
  import lesf_pkg::*;

  // Counter widths follow the grid bounds.
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;

  // Configuration registers.
  char_t empty_char_r;
  size_t row_width_r;

  // Position counters of the next cell to be accepted.
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;

  // Cell stage: accepted cell waiting for its square size.
  logic          s1_valid_r;
  char_t         s1_char_r;
  logic          s1_last_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;

  // Neighbor sizes and running best.
  size_t left_r;
  size_t diag_r;
  size_t best_size_r;
  pos_t  best_row_r;
  pos_t  best_col_r;

  // Output register.
  logic  out_valid_r;
  size_t out_cell_size_r;
  size_t out_best_size_r;
  pos_t  out_best_row_r;
  pos_t  out_best_col_r;
  logic  out_done_r;

  logic          out_advance;
  logic          s1_move;
  logic          accept;
  logic [WW-1:0] eff_width;
  logic [WW-1:0] col_inc;
  logic          row_end;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;
  size_t         up_size;
  size_t         least;
  size_t         size_c;
  logic          better;
  size_t         best_size_nxt;
  pos_t          best_row_nxt;
  pos_t          best_col_nxt;

  // Handshake: the cell stage empties into the output register whenever that
  // register is free or being drained this cycle.
  assign out_advance = !out_valid_r || out_m.ready;
  assign s1_move     = s1_valid_r && out_advance;
  assign in_s.ready  = !s1_valid_r || out_advance;
  assign accept      = in_s.valid && in_s.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_char_r <= EMPTY_CHAR_RST;
      row_width_r  <= ROW_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_EMPTY_CHAR: empty_char_r <= cfg_wdata[CHAR_W-1:0];
        CFG_ROW_WIDTH:  row_width_r  <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // A width of zero counts as one, and a width beyond the store saturates.
  always_comb begin
    eff_width = WW'(row_width_r);
    if (row_width_r == '0) begin
      eff_width = WW'(1);
    end else if (WW'(row_width_r) > WW'(MAX_COLS)) begin
      eff_width = WW'(MAX_COLS);
    end
  end

  // Raster position advance; the last cell of a grid restarts at the origin.
  assign col_inc = WW'(col_r) + WW'(1);
  assign row_end = col_inc >= eff_width;

  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (in_s.last_cell) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      if (row_r < RW'(MAX_ROWS - 1)) begin
        row_nxt = row_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Cell stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_s.ready) begin
      s1_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_char_r <= in_s.cell_char;
      s1_last_r <= in_s.last_cell;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
    end
  end

  // The upper size is read when the cell is accepted; the cell leaving the
  // stage in the same cycle writes its size and is forwarded if it hits.
  lesf_line_store #(
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_move),
    .wr_addr (s1_col_r),
    .wr_data (size_c),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (up_size)
  );

  // Square size of the staged cell: one plus the least neighbor size, or one
  // on the first row and column, and zero for a blocked cell.
  always_comb begin
    least = up_size;
    if (left_r < least) begin
      least = left_r;
    end
    if (diag_r < least) begin
      least = diag_r;
    end
    size_c = '0;
    if (s1_char_r == empty_char_r) begin
      if (s1_row_r == '0 || s1_col_r == '0) begin
        size_c = SIZE_W'(1);
      end else begin
        size_c = least + SIZE_W'(1);
      end
    end
  end

  // Only a strictly larger size moves the best, so ties keep the earlier cell.
  assign better        = size_c > best_size_r;
  assign best_size_nxt = better ? size_c : best_size_r;
  assign best_row_nxt  = better ? POS_W'(32'(s1_row_r)) : best_row_r;
  assign best_col_nxt  = better ? POS_W'(32'(s1_col_r)) : best_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (s1_move) begin
      if (s1_last_r) begin
        left_r      <= '0;
        diag_r      <= '0;
        best_size_r <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else begin
        left_r      <= size_c;
        diag_r      <= up_size;
        best_size_r <= best_size_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_cell_size_r <= size_c;
      out_best_size_r <= best_size_nxt;
      out_best_row_r  <= best_row_nxt;
      out_best_col_r  <= best_col_nxt;
      out_done_r      <= s1_last_r;
    end
  end

  assign out_m.valid     = out_valid_r;
  assign out_m.cell_size = out_cell_size_r;
  assign out_m.best_size = out_best_size_r;
  assign out_m.best_row  = out_best_row_r;
  assign out_m.best_col  = out_best_col_r;
  assign out_m.grid_done = out_done_r;

endmodule

@@ design/lesf_checker.sv @@
// Port-level checker for the largest empty square finder, bound to the top level.
module lesf_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input lesf_pkg::size_t cell_size,
  input lesf_pkg::size_t best_size,
  input lesf_pkg::pos_t  best_row,
  input lesf_pkg::pos_t  best_col,
  input logic            grid_done
);
  import lesf_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(cell_size) && $stable(best_size) &&
      $stable(best_row) && $stable(best_col) && $stable(grid_done))
    else $error("result payload changed while stalled");

  // The running best already includes the current cell.
  a_best_covers_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> best_size >= cell_size)
    else $error("best size below current cell size");

  // With no free square found yet the best position stays at the origin.
  a_empty_best_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && best_size == '0 |-> best_row == '0 && best_col == '0)
    else $error("best position set without a square");

endmodule

bind largest_empty_square_finder_top lesf_checker u_lesf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .cell_size (out_m.cell_size),
  .best_size (out_m.best_size),
  .best_row  (out_m.best_row),
  .best_col  (out_m.best_col),
  .grid_done (out_m.grid_done)
);
